// File: hdl/rzag_pkg.sv
`timescale 1ns / 1ps

package rzag_pkg;

	localparam int ACC_W      = 32;
	localparam int POS_W      = 10;
	localparam int STEP_W     = 12;
	localparam int SIZE_W     = 11;
	localparam int CFG_W      = 12;
	localparam int IDX_W      = 3;
	// remainder bits resolved per cycle in the wrap unit
	localparam int WRAP_STEPS = 8;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [ACC_W-1:0] acc_u;
		logic [ACC_W-1:0] acc_v;
		logic             row_end;
		logic             frame_end;
	} pix_t;

endpackage

// File: hdl/rotozoom_texture_address_gen.sv
// The floor-modulo wrap unit resolves 8 remainder bits per cycle and works on one pixel
//   at a time, popping the next pixel from the queue only as the current one finishes.
// A two-entry queue decouples the accumulator walk from the wrap unit.
// Reset (arst_n low): walk state cleared, registers to defaults, no clearing pass.
`timescale 1ns / 1ps

module rotozoom_texture_address_gen #(
	parameter int MAX_DIM   = 1024,
	parameter int FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rzag_pkg::IDX_W-1:0]     cfg_index,
	input  logic [rzag_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           frame_start,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rzag_pkg::POS_W-1:0]     out_col,
	output logic [rzag_pkg::POS_W-1:0]     out_row,
	output logic [rzag_pkg::POS_W-1:0]     tex_col,
	output logic [rzag_pkg::POS_W-1:0]     tex_row,
	output logic                           row_end,
	output logic                           frame_end
);

	localparam int STEP_W = rzag_pkg::STEP_W;
	localparam int SIZE_W = rzag_pkg::SIZE_W;
	localparam int IDX_W  = rzag_pkg::IDX_W;

	localparam logic [IDX_W-1:0] REG_STEP_U     = 3'd0;
	localparam logic [IDX_W-1:0] REG_STEP_V     = 3'd1;
	localparam logic [IDX_W-1:0] REG_TEX_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_TEX_HEIGHT = 3'd3;
	localparam logic [IDX_W-1:0] REG_SCR_WIDTH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SCR_HEIGHT = 3'd5;

	logic [STEP_W-1:0] step_u_q, step_v_q;
	logic [SIZE_W-1:0] tex_w_q, tex_h_q, scr_w_q, scr_h_q;

	logic           q_push, q_pop, q_full, q_empty;
	rzag_pkg::pix_t q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_u_q <= 12'd256;
			step_v_q <= 12'd0;
			tex_w_q  <= 11'd80;
			tex_h_q  <= 11'd24;
			scr_w_q  <= 11'd80;
			scr_h_q  <= 11'd24;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_U:     step_u_q <= cfg_data[STEP_W-1:0];
				REG_STEP_V:     step_v_q <= cfg_data[STEP_W-1:0];
				REG_TEX_WIDTH:  tex_w_q  <= cfg_data[SIZE_W-1:0];
				REG_TEX_HEIGHT: tex_h_q  <= cfg_data[SIZE_W-1:0];
				REG_SCR_WIDTH:  scr_w_q  <= cfg_data[SIZE_W-1:0];
				REG_SCR_HEIGHT: scr_h_q  <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	rzag_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.frame_start  (frame_start),
		.step_u       (step_u_q),
		.step_v       (step_v_q),
		.screen_width (scr_w_q),
		.screen_height(scr_h_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_in)
	);

	rzag_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.entry_in (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.entry_out(q_out)
	);

	rzag_wrap #(
		.MAX_DIM  (MAX_DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_wrap (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_entry       (q_out),
		.texture_width (tex_w_q),
		.texture_height(tex_h_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_col       (out_col),
		.out_row       (out_row),
		.tex_col       (tex_col),
		.tex_row       (tex_row),
		.row_end       (row_end),
		.frame_end     (frame_end)
	);

endmodule

// File: hdl/rzag_front.sv
`timescale 1ns / 1ps

module rzag_front #(
	parameter int MAX_DIM = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              frame_start,
	input  logic [rzag_pkg::STEP_W-1:0]       step_u,
	input  logic [rzag_pkg::STEP_W-1:0]       step_v,
	input  logic [rzag_pkg::SIZE_W-1:0]       screen_width,
	input  logic [rzag_pkg::SIZE_W-1:0]       screen_height,
	input  logic                              q_full,
	output logic                              q_push,
	output rzag_pkg::pix_t                    q_entry
);

	localparam int ACC_W = rzag_pkg::ACC_W;
	localparam int POS_W = rzag_pkg::POS_W;
	localparam int MW    = $clog2(MAX_DIM + 1);
	localparam int EW    = (MW > rzag_pkg::SIZE_W) ? MW : rzag_pkg::SIZE_W;
	localparam int CW    = (MW > POS_W) ? MW : POS_W;

	logic [ACC_W-1:0] acc_u_q, acc_v_q, rs_u_q, rs_v_q;
	logic [POS_W-1:0] col_q, row_q;

	logic [ACC_W-1:0] su, sv, base_u, base_v, rsb_u, rsb_v, nxt_u, nxt_v;
	logic [ACC_W-1:0] rs_nu, rs_nv;
	logic [POS_W-1:0] col, row;
	logic [EW-1:0]    sw_ext, sh_ext;
	logic [MW-1:0]    sw_eff, sh_eff;
	logic             rend, fend, accept;

	always_comb begin
		sw_ext = EW'(screen_width);
		sh_ext = EW'(screen_height);
		if (sw_ext == '0) begin
			sw_eff = MW'(1);
		end else if (sw_ext > EW'(MAX_DIM)) begin
			sw_eff = MW'(MAX_DIM);
		end else begin
			sw_eff = MW'(sw_ext);
		end
		if (sh_ext == '0) begin
			sh_eff = MW'(1);
		end else if (sh_ext > EW'(MAX_DIM)) begin
			sh_eff = MW'(MAX_DIM);
		end else begin
			sh_eff = MW'(sh_ext);
		end
	end

	always_comb begin
		su     = {{(ACC_W-rzag_pkg::STEP_W){step_u[rzag_pkg::STEP_W-1]}}, step_u};
		sv     = {{(ACC_W-rzag_pkg::STEP_W){step_v[rzag_pkg::STEP_W-1]}}, step_v};
		base_u = frame_start ? '0 : acc_u_q;
		base_v = frame_start ? '0 : acc_v_q;
		rsb_u  = frame_start ? '0 : rs_u_q;
		rsb_v  = frame_start ? '0 : rs_v_q;
		col    = frame_start ? '0 : col_q;
		row    = frame_start ? '0 : row_q;
		nxt_u  = base_u + su;
		nxt_v  = base_v + sv;
		// next row starts one perpendicular step further
		rs_nu  = rsb_u - sv;
		rs_nv  = rsb_v + su;
		rend   = CW'(col) >= (CW'(sw_eff) - CW'(1));
		fend   = rend && (CW'(row) >= (CW'(sh_eff) - CW'(1)));
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	always_comb begin
		q_entry.col       = col;
		q_entry.row       = row;
		q_entry.acc_u     = nxt_u;
		q_entry.acc_v     = nxt_v;
		q_entry.row_end   = rend;
		q_entry.frame_end = fend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_u_q <= '0;
			acc_v_q <= '0;
			rs_u_q  <= '0;
			rs_v_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (accept) begin
			if (fend) begin
				acc_u_q <= '0;
				acc_v_q <= '0;
				rs_u_q  <= '0;
				rs_v_q  <= '0;
				col_q   <= '0;
				row_q   <= '0;
			end else if (rend) begin
				acc_u_q <= rs_nu;
				acc_v_q <= rs_nv;
				rs_u_q  <= rs_nu;
				rs_v_q  <= rs_nv;
				col_q   <= '0;
				row_q   <= row + POS_W'(1);
			end else begin
				acc_u_q <= nxt_u;
				acc_v_q <= nxt_v;
				rs_u_q  <= rsb_u;
				rs_v_q  <= rsb_v;
				col_q   <= col + POS_W'(1);
				row_q   <= row;
			end
		end
	end

endmodule

// File: hdl/rzag_queue.sv
`timescale 1ns / 1ps

module rzag_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rzag_pkg::pix_t entry_in,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output rzag_pkg::pix_t entry_out
);

	localparam int DEPTH = 2;

	rzag_pkg::pix_t ent_q [DEPTH];
	logic           wr_q, rd_q;
	logic [1:0]     count_q;

	assign full      = (count_q == 2'(DEPTH));
	assign empty     = (count_q == '0);
	assign entry_out = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(DEPTH))
		else $error("queue count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count missed a request");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 2'd1)
		else $error("queue count missed a pop");

endmodule

// File: hdl/rzag_wrap.sv
`timescale 1ns / 1ps

module rzag_wrap #(
	parameter int MAX_DIM   = 1024,
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  rzag_pkg::pix_t                q_entry,
	input  logic [rzag_pkg::SIZE_W-1:0]   texture_width,
	input  logic [rzag_pkg::SIZE_W-1:0]   texture_height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rzag_pkg::POS_W-1:0]    out_col,
	output logic [rzag_pkg::POS_W-1:0]    out_row,
	output logic [rzag_pkg::POS_W-1:0]    tex_col,
	output logic [rzag_pkg::POS_W-1:0]    tex_row,
	output logic                          row_end,
	output logic                          frame_end
);

	localparam int ACC_W  = rzag_pkg::ACC_W;
	localparam int POS_W  = rzag_pkg::POS_W;
	localparam int STEPS  = rzag_pkg::WRAP_STEPS;
	localparam int QW     = ACC_W - FRAC_BITS;
	localparam int NB_RAW = QW - 1;
	localparam int NCYC   = (NB_RAW + STEPS - 1) / STEPS;
	localparam int NB     = NCYC * STEPS;
	localparam int CNT_W  = $clog2(NCYC + 1);
	localparam int MW     = $clog2(MAX_DIM + 1);
	localparam int EW     = (MW > rzag_pkg::SIZE_W) ? MW : rzag_pkg::SIZE_W;

	// one restoring step per bit: r = (2r + b) mod m, r stays below m
	function automatic logic [MW-1:0] mod_steps(input logic [MW-1:0] r,
		input logic [STEPS-1:0] bits, input logic [MW-1:0] m);
		logic [MW:0]   t;
		logic [MW-1:0] acc;
		acc = r;
		for (int i = 0; i < STEPS; i++) begin
			t = {acc, bits[STEPS-1-i]};
			if (t >= {1'b0, m}) begin
				t = t - {1'b0, m};
			end
			acc = t[MW-1:0];
		end
		return acc;
	endfunction

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NB-1:0]       shu_q, shv_q;
	logic [MW-1:0]       ru_q, rv_q;
	logic [POS_W-1:0]    col_q, row_q;
	logic                rend_q, fend_q;

	logic [EW-1:0]       tw_ext, th_ext;
	logic [MW-1:0]       mu, mv, ru_n, rv_n;
	logic signed [QW-1:0] qu, qv;
	logic                last, finish;

	always_comb begin
		tw_ext = EW'(texture_width);
		th_ext = EW'(texture_height);
		if (tw_ext == '0) begin
			mu = MW'(1);
		end else if (tw_ext > EW'(MAX_DIM)) begin
			mu = MW'(MAX_DIM);
		end else begin
			mu = MW'(tw_ext);
		end
		if (th_ext == '0) begin
			mv = MW'(1);
		end else if (th_ext > EW'(MAX_DIM)) begin
			mv = MW'(MAX_DIM);
		end else begin
			mv = MW'(th_ext);
		end
	end

	// integer part by arithmetic shift (floor); sign bit seeds the remainder
	assign qu = q_entry.acc_u[ACC_W-1:FRAC_BITS];
	assign qv = q_entry.acc_v[ACC_W-1:FRAC_BITS];

	assign ru_n   = mod_steps(ru_q, shu_q[NB-1 -: STEPS], mu);
	assign rv_n   = mod_steps(rv_q, shv_q[NB-1 -: STEPS], mv);
	assign last   = (cnt_q == CNT_W'(NCYC));
	assign finish = busy_q && last && (!out_valid || out_ready);
	assign q_pop  = !q_empty && (!busy_q || finish);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			shu_q  <= NB'(qu);
			shv_q  <= NB'(qv);
			ru_q   <= q_entry.acc_u[ACC_W-1] ? (mu - MW'(1)) : '0;
			rv_q   <= q_entry.acc_v[ACC_W-1] ? (mv - MW'(1)) : '0;
			col_q  <= q_entry.col;
			row_q  <= q_entry.row;
			rend_q <= q_entry.row_end;
			fend_q <= q_entry.frame_end;
		end else if (busy_q && !last) begin
			shu_q <= shu_q << STEPS;
			shv_q <= shv_q << STEPS;
			ru_q  <= ru_n;
			rv_q  <= rv_n;
		end
		if (finish) begin
			out_col   <= col_q;
			out_row   <= row_q;
			tex_col   <= POS_W'(ru_q);
			tex_row   <= POS_W'(rv_q);
			row_end   <= rend_q;
			frame_end <= fend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else begin
				if (finish) begin
					busy_q <= 1'b0;
				end
				if (busy_q && !last) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (ru_q < mu) && (rv_q < mv))
		else $error("wrap remainder out of range");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= CNT_W'(NCYC))
		else $error("wrap step count overran");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid && (tex_col == POS_W'($past(ru_q))))
		else $error("finished pixel not presented");

endmodule
